[rtl/tecq_pkg.sv]
// ----------------------------------------------------------------------------
// tecq_pkg
// Shared types and constants of the touch event queue with move coalescing.
// ----------------------------------------------------------------------------
package tecq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int COORD_BITS  = 12;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } tecq_cmd_e;

  typedef enum logic [1:0] {
    KIND_DOWN = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_UP   = 2'd2
  } tecq_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_DISABLED = 2'd2
  } tecq_status_e;

  typedef struct packed {
    logic [1:0]            kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } tecq_entry_t;

  typedef struct packed {
    logic             shift;
    logic             load;
    logic             coal;
    logic [IDX_W-1:0] slot;
  } tecq_cell_ctl_t;

endpackage

[rtl/tecq_cell.sv]
// ----------------------------------------------------------------------------
// tecq_cell
// One queue slot: holds an event, takes its right neighbor on a shift, loads
// a new event or coalesces move coordinates when addressed.
// ----------------------------------------------------------------------------
module tecq_cell import tecq_pkg::*; (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [IDX_W-1:0] tail_i,
  input  tecq_cell_ctl_t   ctl_i,
  input  tecq_entry_t      new_i,
  input  tecq_entry_t      right_i,
  output tecq_entry_t      data_o,
  output logic             tail_move_o
);

  tecq_entry_t data_q, data_d;
  logic        hit;

  assign hit         = (ctl_i.slot == idx_i);
  assign data_o      = data_q;
  assign tail_move_o = (tail_i == idx_i) && (data_q.kind == KIND_MOVE);

  always_comb begin
    data_d = data_q;
    if (ctl_i.load && hit) begin
      data_d = new_i;
    end else if (ctl_i.coal && hit) begin
      data_d.x = new_i.x;
      data_d.y = new_i.y;
    end else if (ctl_i.shift) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

[rtl/touch_event_queue_coalescing.sv]
// ----------------------------------------------------------------------------
// touch_event_queue_coalescing
// Classifies pointer samples into down, move and up events and queues them
// in a shifting row of cells, merging consecutive moves.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid_i/in_ready_o   command, sample x/y/pressed
//  out       output     out_valid_o/out_ready_i status, event, pointer, queued
//  cfg       input      cfg_we_i                touch_enabled
//
//  One transaction per cycle while results are taken; its result appears the cycle after acceptance.
//  The queue cells update in that same cycle: pops and full-queue pushes
//  that do not coalesce shift the whole row toward the head cell in one step.
//  Reset clears the pointer, the fill count, the enable and the output valid.
//  A stalled result holds the input off until it is taken or taken same cycle.
module touch_event_queue_coalescing import tecq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  logic [COORD_BITS-1:0] sample_x_i,
  input  logic [COORD_BITS-1:0] sample_y_i,
  input  logic                  sample_pressed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic                  event_valid_o,
  output logic [1:0]            event_kind_o,
  output logic [COORD_BITS-1:0] event_x_o,
  output logic [COORD_BITS-1:0] event_y_o,
  output logic [COORD_BITS-1:0] cursor_x_o,
  output logic [COORD_BITS-1:0] cursor_y_o,
  output logic                  pointer_down_o,
  output logic [CNT_W-1:0]      queued_o
);

  logic                  enabled_q;
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] last_x_q, last_x_d;
  logic [COORD_BITS-1:0] last_y_q, last_y_d;
  logic                  last_p_q, last_p_d;
  logic [CNT_W-1:0]      count_q, count_d;
  tecq_status_e          status_q, status_d;
  logic                  ev_valid_q, ev_valid_d;
  tecq_entry_t           ev_q, ev_d;

  logic                  accept;
  tecq_cmd_e             cmd;
  tecq_kind_e            kind;
  tecq_entry_t           new_entry;
  tecq_cell_ctl_t        ctl;
  logic [IDX_W-1:0]      tail_idx;
  tecq_entry_t           cell_data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] tail_move;
  logic                  count_zero;
  logic                  count_full;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = tecq_cmd_e'(command_i);
  assign count_zero = (count_q == '0);
  assign count_full = (count_q == CNT_W'(QUEUE_DEPTH));
  assign tail_idx   = IDX_W'(count_q - CNT_W'(1));

  always_comb begin
    if (!last_p_q && sample_pressed_i) begin
      kind = KIND_DOWN;
    end else if (last_p_q && !sample_pressed_i) begin
      kind = KIND_UP;
    end else begin
      kind = KIND_MOVE;
    end
  end

  assign new_entry.kind = kind;
  assign new_entry.x    = sample_x_i;
  assign new_entry.y    = sample_y_i;

  always_comb begin
    last_x_d   = last_x_q;
    last_y_d   = last_y_q;
    last_p_d   = last_p_q;
    count_d    = count_q;
    status_d   = STATUS_OK;
    ev_valid_d = 1'b0;
    ev_d       = '0;
    ctl.shift  = 1'b0;
    ctl.load   = 1'b0;
    ctl.coal   = 1'b0;
    ctl.slot   = count_q[IDX_W-1:0];
    if (accept) begin
      case (cmd)
        CMD_SAMPLE: begin
          last_x_d = sample_x_i;
          last_y_d = sample_y_i;
          last_p_d = sample_pressed_i;
          if (enabled_q) begin
            if (kind == KIND_MOVE && !count_zero && (|tail_move)) begin
              ctl.coal = 1'b1;
              ctl.slot = tail_idx;
            end else if (count_full) begin
              ctl.shift = 1'b1;
              ctl.load  = 1'b1;
              ctl.slot  = IDX_W'(QUEUE_DEPTH - 1);
            end else begin
              ctl.load = 1'b1;
              count_d  = count_q + CNT_W'(1);
            end
          end
        end
        CMD_POLL: begin
          if (!enabled_q) begin
            status_d = STATUS_DISABLED;
          end else if (count_zero) begin
            status_d = STATUS_EMPTY;
          end else begin
            ev_valid_d = 1'b1;
            ev_d       = cell_data[0];
            ctl.shift  = 1'b1;
            count_d    = count_q - CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tecq_entry_t right;
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end
    tecq_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(i)),
      .tail_i      (tail_idx),
      .ctl_i       (ctl),
      .new_i       (new_entry),
      .right_i     (right),
      .data_o      (cell_data[i]),
      .tail_move_o (tail_move[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      out_valid_q <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_p_q    <= 1'b0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      last_x_q <= last_x_d;
      last_y_q <= last_y_d;
      last_p_q <= last_p_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      ev_valid_q <= ev_valid_d;
      ev_q       <= ev_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign event_valid_o  = ev_valid_q;
  assign event_kind_o   = ev_q.kind;
  assign event_x_o      = ev_q.x;
  assign event_y_o      = ev_q.y;
  assign cursor_x_o     = last_x_q;
  assign cursor_y_o     = last_y_q;
  assign pointer_down_o = last_p_q;
  assign queued_o       = count_q;

endmodule

[rtl/tecq_checker.sv]
// ----------------------------------------------------------------------------
// tecq_checker
// Port-level checks of the touch event queue, bound to the top level.
// ----------------------------------------------------------------------------
module tecq_checker import tecq_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic                  cfg_wdata_i,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [1:0]            command_i,
  input logic [COORD_BITS-1:0] sample_x_i,
  input logic [COORD_BITS-1:0] sample_y_i,
  input logic                  sample_pressed_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [1:0]            status_o,
  input logic                  event_valid_o,
  input logic [1:0]            event_kind_o,
  input logic [COORD_BITS-1:0] event_x_o,
  input logic [COORD_BITS-1:0] event_y_o,
  input logic [COORD_BITS-1:0] cursor_x_o,
  input logic [COORD_BITS-1:0] cursor_y_o,
  input logic                  pointer_down_o,
  input logic [CNT_W-1:0]      queued_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(event_x_o) && $stable(event_y_o) && $stable(queued_o))
    else $error("result changed while stalled");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queued_o <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i == CMD_CLEAR |=> queued_o == '0)
    else $error("clear left events queued");

  a_sample_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i == CMD_SAMPLE
      |=> cursor_x_o == $past(sample_x_i) && pointer_down_o == $past(sample_pressed_i))
    else $error("pointer not updated by sample");

  a_event_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_valid_o |-> status_o == STATUS_OK)
    else $error("event returned with error status");

endmodule

bind touch_event_queue_coalescing tecq_checker u_tecq_checker (.*);

[tb/tb_touch_event_queue_coalescing.sv]
// ----------------------------------------------------------------------------
// tb_touch_event_queue_coalescing
// Drives commands and pointer samples into the touch event queue. A local
// model classifies each sample, coalesces moves, drops the oldest entry on a
// full queue and pops on polls. Every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_touch_event_queue_coalescing;
  timeunit 1ns;
  timeprecision 1ps;
  import tecq_pkg::*;

  typedef struct {
    tecq_cmd_e             cmd;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  pressed;
  } touch_cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  ev_valid;
    logic [1:0]            kind;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  pdown;
    logic [CNT_W-1:0]      queued;
  } touch_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_wdata_i = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            command_i = CMD_SAMPLE;
  logic [COORD_BITS-1:0] sample_x_i = '0;
  logic [COORD_BITS-1:0] sample_y_i = '0;
  logic                  sample_pressed_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            status_o;
  logic                  event_valid_o;
  logic [1:0]            event_kind_o;
  logic [COORD_BITS-1:0] event_x_o;
  logic [COORD_BITS-1:0] event_y_o;
  logic [COORD_BITS-1:0] cursor_x_o;
  logic [COORD_BITS-1:0] cursor_y_o;
  logic                  pointer_down_o;
  logic [CNT_W-1:0]      queued_o;

  touch_event_queue_coalescing dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .sample_x_i       (sample_x_i),
    .sample_y_i       (sample_y_i),
    .sample_pressed_i (sample_pressed_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .event_valid_o    (event_valid_o),
    .event_kind_o     (event_kind_o),
    .event_x_o        (event_x_o),
    .event_y_o        (event_y_o),
    .cursor_x_o       (cursor_x_o),
    .cursor_y_o       (cursor_y_o),
    .pointer_down_o   (pointer_down_o),
    .queued_o         (queued_o)
  );

  touch_cmd_t    pending_cmds[$];
  touch_result_t due_results[$];
  touch_cmd_t    next_cmd;
  touch_result_t got_result;
  touch_result_t want_result;
  bit            in_busy = 1'b0;
  int            send_idle_pct = 18;
  int            recv_idle_pct = 76;
  int            err_count = 0;
  logic          gesture_down = 1'b0;

  tecq_entry_t           ring[QUEUE_DEPTH];
  int                    ring_head = 0;
  int                    ring_fill = 0;
  logic [COORD_BITS-1:0] ptr_x = '0;
  logic [COORD_BITS-1:0] ptr_y = '0;
  logic                  ptr_down = 1'b0;
  logic                  touch_on = 1'b0;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic touch_result_t apply_command(input touch_cmd_t c);
    touch_result_t r;
    tecq_kind_e    k;
    int            newest;
    r = '0;
    case (c.cmd)
      CMD_SAMPLE: begin
        k = KIND_MOVE;
        if (!ptr_down && c.pressed) begin
          k = KIND_DOWN;
        end else if (ptr_down && !c.pressed) begin
          k = KIND_UP;
        end
        ptr_x = c.x;
        ptr_y = c.y;
        ptr_down = c.pressed;
        if (touch_on) begin
          newest = (ring_head + ring_fill + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          if (k == KIND_MOVE && ring_fill != 0 && ring[newest].kind == KIND_MOVE) begin
            ring[newest].x = c.x;
            ring[newest].y = c.y;
          end else begin
            if (ring_fill == QUEUE_DEPTH) begin
              ring_head = (ring_head + 1) % QUEUE_DEPTH;
              ring_fill--;
            end
            ring[(ring_head + ring_fill) % QUEUE_DEPTH] = '{kind: k, x: c.x, y: c.y};
            ring_fill++;
          end
        end
      end
      CMD_POLL: begin
        if (!touch_on) begin
          r.status = STATUS_DISABLED;
        end else if (ring_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.status = STATUS_OK;
          r.ev_valid = 1'b1;
          r.kind = ring[ring_head].kind;
          r.ex = ring[ring_head].x;
          r.ey = ring[ring_head].y;
          ring_head = (ring_head + 1) % QUEUE_DEPTH;
          ring_fill--;
        end
      end
      CMD_CLEAR: begin
        ring_head = 0;
        ring_fill = 0;
      end
      default: begin
      end
    endcase
    r.px = ptr_x;
    r.py = ptr_y;
    r.pdown = ptr_down;
    r.queued = CNT_W'(ring_fill);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (!in_busy) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        command_i <= next_cmd.cmd;
        sample_x_i <= next_cmd.x;
        sample_y_i <= next_cmd.y;
        sample_pressed_i <= next_cmd.pressed;
        in_valid_i <= 1'b1;
        in_busy = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        touch_on = cfg_wdata_i;
      end
      if (out_valid_o && out_ready_i) begin
        got_result = '{status: status_o, ev_valid: event_valid_o, kind: event_kind_o,
                       ex: event_x_o, ey: event_y_o, px: cursor_x_o, py: cursor_y_o,
                       pdown: pointer_down_o, queued: queued_o};
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want_result = due_results.pop_front();
          if (got_result.status !== want_result.status)
            report_mismatch("status", got_result.status, want_result.status);
          if (got_result.ev_valid !== want_result.ev_valid)
            report_mismatch("event_valid", got_result.ev_valid, want_result.ev_valid);
          if (got_result.kind !== want_result.kind)
            report_mismatch("event_kind", got_result.kind, want_result.kind);
          if (got_result.ex !== want_result.ex)
            report_mismatch("event_x", got_result.ex, want_result.ex);
          if (got_result.ey !== want_result.ey)
            report_mismatch("event_y", got_result.ey, want_result.ey);
          if (got_result.px !== want_result.px)
            report_mismatch("cursor_x", got_result.px, want_result.px);
          if (got_result.py !== want_result.py)
            report_mismatch("cursor_y", got_result.py, want_result.py);
          if (got_result.pdown !== want_result.pdown)
            report_mismatch("pointer_down", got_result.pdown, want_result.pdown);
          if (got_result.queued !== want_result.queued)
            report_mismatch("queued", got_result.queued, want_result.queued);
        end
      end
      if (in_valid_i && in_ready_o) begin
        due_results.push_back(apply_command('{cmd: tecq_cmd_e'(command_i), x: sample_x_i,
                                             y: sample_y_i, pressed: sample_pressed_i}));
        in_busy = 1'b0;
      end
    end
  end

  task automatic push_cmd(input tecq_cmd_e cmd, input logic [COORD_BITS-1:0] x,
                          input logic [COORD_BITS-1:0] y, input logic pressed);
    pending_cmds.push_back('{cmd: cmd, x: x, y: y, pressed: pressed});
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_busy || due_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_touch(input logic value);
    wait_drained();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
    endcase
  endfunction

  task automatic run_random(input int count);
    int mode_left;
    bit filling;
    int roll;
    mode_left = 0;
    filling = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (mode_left == 0) begin
        filling = $urandom_range(0, 2) != 0;
        mode_left = $urandom_range(10, 40);
      end
      mode_left--;
      roll = $urandom_range(0, 99);
      if (roll < (filling ? 80 : 30)) begin
        if ($urandom_range(0, 9) < 4) begin
          gesture_down = ~gesture_down;
        end
        push_cmd(CMD_SAMPLE, pick_coord(), pick_coord(), gesture_down);
      end else if (roll < (filling ? 95 : 93)) begin
        push_cmd(CMD_POLL, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
      end else if (roll < (filling ? 97 : 96)) begin
        push_cmd(CMD_CLEAR, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
      end else begin
        push_cmd(CMD_NOP, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_cmd(CMD_SAMPLE, 12'd4095, 12'd0, 1'b1);
    push_cmd(CMD_POLL, 12'd0, 12'd0, 1'b0);
    push_cmd(CMD_CLEAR, 12'd0, 12'd0, 1'b0);
    push_cmd(CMD_NOP, 12'd4095, 12'd4095, 1'b1);
    push_cmd(CMD_SAMPLE, 12'd0, 12'd4095, 1'b0);
    set_touch(1'b1);
    push_cmd(CMD_POLL, 12'd0, 12'd0, 1'b0);
    push_cmd(CMD_SAMPLE, 12'd4095, 12'd4095, 1'b1);
    push_cmd(CMD_SAMPLE, 12'd0, 12'd0, 1'b1);
    push_cmd(CMD_SAMPLE, 12'd4095, 12'd0, 1'b1);
    push_cmd(CMD_SAMPLE, 12'd0, 12'd4095, 1'b0);
    push_cmd(CMD_POLL, 12'd0, 12'd0, 1'b0);
    for (int i = 0; i < 15; i++) begin
      push_cmd(CMD_SAMPLE, COORD_BITS'(i * 273), COORD_BITS'(4095 - i * 273), i % 2 == 0);
    end
    push_cmd(CMD_CLEAR, 12'd0, 12'd0, 1'b0);
    gesture_down = 1'b0;

    run_random(150);
    set_touch(1'b0);
    run_random(40);
    send_idle_pct = 76;
    recv_idle_pct = 18;
    set_touch(1'b1);
    run_random(150);
    set_touch(1'b0);
    run_random(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_touch(1'b1);
    run_random(150);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_touch_event_queue_coalescing: done, clean");
    end else begin
      $display("tb_touch_event_queue_coalescing: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_touch_event_queue_coalescing: done, errors");
    $finish;
  end

endmodule

[files.f]
rtl/tecq_pkg.sv
rtl/tecq_cell.sv
rtl/touch_event_queue_coalescing.sv
rtl/tecq_checker.sv
tb/tb_touch_event_queue_coalescing.sv
